// ===== sv/pce_pkg.sv =====
// Shared types, field widths and codes for the palette cycle engine.
`default_nettype none

package pce_pkg;

	localparam int MAX_COLORS_DEF = 256;
	localparam int MAX_EMIT_DEF   = 64;

	localparam int DUR_DEPTH = 512;
	localparam int DUR_AW    = 9;
	localparam int FRAC_BITS = 8;

	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 9;
	localparam int COLOR_W  = 16;
	localparam int DUR_W    = 16;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_COLOR = 2'd0,
		MODE_LOAD_DUR   = 2'd1,
		MODE_QUERY      = 2'd2
	} pce_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EFFECT_MODE = 2'd0,
		REG_RUN_LEN     = 2'd1
	} pce_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} pce_state_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               last;
	} pce_word_t;

endpackage

`default_nettype wire

// ===== sv/pce_ifs.sv =====
// Valid/ready channel interfaces: request items, result words, register writes.
`default_nettype none

interface pce_req_if;
	import pce_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [INDEX_W-1:0]        entry_index;
	logic [COLOR_W-1:0]        color_value;
	logic signed [DUR_W-1:0]   step_duration;
	logic signed [TIME_W-1:0]  query_time;
	logic [COUNT_W-1:0]        emit_count;

	modport source (output valid, mode, entry_index, color_value, step_duration,
		query_time, emit_count, input ready);
	modport sink (input valid, mode, entry_index, color_value, step_duration,
		query_time, emit_count, output ready);
endinterface

interface pce_rsp_if;
	import pce_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_color;
	logic               last_of_run;

	modport source (output valid, out_color, last_of_run, input ready);
	modport sink (input valid, out_color, last_of_run, output ready);
endinterface

interface pce_cfg_if;
	import pce_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/palette_cycle_engine.sv =====
// Palette cycle engine: color and duration stores, phase search and color emission.
//
// Each load writes the color store or the duration store and leaves the block ready for
// the next item. An accepted query walks the duration store at one entry per cycle
// through its single registered read port (up to the run length in rotate mode, twice
// that in ping-pong mode), then reads one color per cycle, while the two-word output
// queue has room, from the color store into that queue. The next item is accepted once
// the last color read of a query has been issued, or once the search ends if the query
// asks for no colors; colors still queued drain while it runs.
`default_nettype none

module palette_cycle_engine #(
	parameter int MAX_COLORS = pce_pkg::MAX_COLORS_DEF,
	parameter int MAX_EMIT   = pce_pkg::MAX_EMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pce_req_if.sink      req,
	pce_rsp_if.source    rsp,
	pce_cfg_if.sink      cfg
);
	import pce_pkg::*;

	localparam int CIW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int LW  = $clog2(MAX_COLORS + 1);
	localparam int SW  = LW + 1;
	localparam int EW  = $clog2(MAX_EMIT + 1);

	// storage
	logic [COLOR_W-1:0] color_mem [MAX_COLORS];
	logic [DUR_W-1:0]   dur_mem [DUR_DEPTH];

	// configuration
	logic           effect_q;
	logic [8:0]     ccount_q;

	// query context
	pce_state_t     state_q, state_d;
	logic           pp_q;
	logic [LW-1:0]  len_q;
	logic [SW-1:0]  steps_q;
	logic [EW-1:0]  rem_q;
	logic [TIME_W-1:0] time_q;
	logic [DUR_AW-1:0] rd_idx_q;
	logic           issued_all_q;
	logic [CIW-1:0] pos_q;
	logic           down_q;

	// duration read pipeline
	logic              dval_s1;
	logic [DUR_AW-1:0] didx_s1;
	logic [DUR_W-1:0]  dur_s1;

	// color read pipeline
	logic               cval_s1;
	logic               clast_s1;
	logic [COLOR_W-1:0] col_s1;

	// output queue
	pce_word_t  fifo_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] occ_q;

	logic              acc, is_query;
	logic [TIME_W-1:0] sub;
	logic              hit, end_tab, search_done, issue_dur, issue_col, pop;
	logic [9:0]        s10, p10, len10;
	logic [CIW-1:0]    pos_start;
	logic              down_start;
	logic [LW-1:0]     len_in;
	logic [EW-1:0]     cnt_in;
	logic [2:0]        credit;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign is_query  = (req.mode == MODE_QUERY);
	assign pop       = rsp.valid && rsp.ready;

	assign rsp.valid       = (occ_q != 2'd0);
	assign rsp.out_color   = fifo_q[rptr_q].color;
	assign rsp.last_of_run = fifo_q[rptr_q].last;

	always_comb begin
		if (ccount_q == 9'd0) begin
			len_in = LW'(1);
		end else if ({1'b0, ccount_q} > 10'(MAX_COLORS)) begin
			len_in = LW'(MAX_COLORS);
		end else begin
			len_in = LW'(ccount_q);
		end
		if (req.emit_count > COUNT_W'(MAX_EMIT)) begin
			cnt_in = EW'(MAX_EMIT);
		end else begin
			cnt_in = EW'(req.emit_count);
		end
	end

	// phase search: subtract one duration per cycle as it arrives from the store
	always_comb begin
		sub = time_q - {{8{dur_s1[DUR_W-1]}}, dur_s1, {FRAC_BITS{1'b0}}};
		hit = dval_s1 && sub[TIME_W-1];
		end_tab = dval_s1 && !sub[TIME_W-1] && (10'(didx_s1) == 10'(steps_q) - 10'd1);
		search_done = (state_q == ST_SEARCH) && (hit || end_tab);
		s10   = hit ? 10'(didx_s1) : 10'd0;
		len10 = 10'(len_q);
		p10   = 10'(steps_q) - 10'd1 - s10;
		if (pp_q && (s10 >= len10)) begin
			pos_start  = CIW'(p10);
			down_start = 1'b1;
		end else begin
			pos_start  = CIW'(s10);
			down_start = 1'b0;
		end
	end

	always_comb begin
		credit    = 3'(occ_q) + 3'(cval_s1) - 3'(pop);
		issue_dur = (state_q == ST_SEARCH) && !issued_all_q && !search_done;
		issue_col = (state_q == ST_EMIT) && (credit < 3'd2);
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && is_query) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_done) begin
					state_d = (rem_q == '0) ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (issue_col && rem_q == EW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			effect_q     <= 1'b0;
			ccount_q     <= 9'd1;
			issued_all_q <= 1'b0;
			dval_s1      <= 1'b0;
			cval_s1      <= 1'b0;
			wptr_q       <= 1'b0;
			rptr_q       <= 1'b0;
			occ_q        <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_EFFECT_MODE: effect_q <= cfg.data[0];
					REG_RUN_LEN:     ccount_q <= cfg.data;
					default: ;
				endcase
			end
			dval_s1 <= issue_dur;
			cval_s1 <= issue_col;
			if (acc && is_query) begin
				issued_all_q <= 1'b0;
			end else if (issue_dur && (10'(rd_idx_q) == 10'(steps_q) - 10'd1)) begin
				issued_all_q <= 1'b1;
			end
			if (cval_s1) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			occ_q <= 2'(credit);
		end
	end

	// query context and walk position
	always_ff @(posedge clk) begin
		if (acc && is_query) begin
			pp_q     <= effect_q;
			len_q    <= len_in;
			steps_q  <= effect_q ? {len_in, 1'b0} : SW'(len_in);
			rem_q    <= cnt_in;
			time_q   <= req.query_time;
			rd_idx_q <= '0;
		end else begin
			if (issue_dur) begin
				rd_idx_q <= rd_idx_q + DUR_AW'(1);
			end
			if (state_q == ST_SEARCH && dval_s1) begin
				time_q <= sub;
			end
			if (issue_col) begin
				rem_q <= rem_q - EW'(1);
			end
		end
		if (search_done) begin
			pos_q  <= pos_start;
			down_q <= down_start;
		end else if (issue_col) begin
			if (!pp_q) begin
				pos_q <= (LW'(pos_q) == len_q - LW'(1)) ? '0 : pos_q + CIW'(1);
			end else if (down_q) begin
				if (pos_q == '0) begin
					down_q <= 1'b0;
				end else begin
					pos_q <= pos_q - CIW'(1);
				end
			end else if (LW'(pos_q) == len_q - LW'(1)) begin
				down_q <= 1'b1;
			end else begin
				pos_q <= pos_q + CIW'(1);
			end
		end
		didx_s1  <= rd_idx_q;
		clast_s1 <= (rem_q == EW'(1));
		if (cval_s1) begin
			fifo_q[wptr_q] <= '{color: col_s1, last: clast_s1};
		end
	end

	// stores: one write port and one registered read port each
	always_ff @(posedge clk) begin
		if (acc && req.mode == MODE_LOAD_DUR) begin
			dur_mem[req.entry_index] <= req.step_duration;
		end
		dur_s1 <= dur_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (acc && req.mode == MODE_LOAD_COLOR && 10'(req.entry_index) < 10'(MAX_COLORS)) begin
			color_mem[CIW'(req.entry_index)] <= req.color_value;
		end
		col_s1 <= color_mem[pos_q];
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(3'(occ_q) + 3'(cval_s1)) <= 3'd2)
		else $error("output queue overrun");
	a_dur_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		dval_s1 |-> $past(state_q == ST_SEARCH))
		else $error("duration word outside search");
	a_col_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cval_s1 |-> $past(state_q == ST_EMIT))
		else $error("color word outside emission");
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("emission with no colors left");
	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		search_done |=> (state_q != ST_SEARCH))
		else $error("search did not end");
`endif

endmodule

`default_nettype wire

// ===== tb/palette_cycle_engine_tb.sv =====
// Self-checking testbench for the palette cycle engine: directed table, random phases.
module palette_cycle_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pce_pkg::*;

	localparam int SETTLE_CYCLES  = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [MODE_W-1:0]        mode;
		logic [INDEX_W-1:0]       idx;
		logic [COLOR_W-1:0]       color;
		logic signed [DUR_W-1:0]  dur;
		logic signed [TIME_W-1:0] qtime;
		logic [COUNT_W-1:0]       cnt;
		bit                       typed;
		logic [COLOR_W-1:0]       exp_color;
		int                       exp_n;
	} stim_row_t;

	typedef struct {
		bit               pingpong;
		logic [CFG_DAT_W-1:0] count_reg;
		int               items;
		int               sender_pct;
		int               stall_pct;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	pce_req_if req_ch();
	pce_rsp_if rsp_ch();
	pce_cfg_if cfg_ch();

	palette_cycle_engine dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	always #4 clk = ~clk;

	// shadow of the block's stores and registers
	logic [COLOR_W-1:0] color_store [MAX_COLORS_DEF];
	bit                 color_known [MAX_COLORS_DEF];
	logic [DUR_W-1:0]   dur_store [DUR_DEPTH];
	bit                 dur_known [DUR_DEPTH];
	bit                 eff_pp  = 1'b0;
	int                 eff_len = 1;

	pce_word_t pending_colors [$];
	pce_word_t head_word;

	int mismatches = 0;
	int sender_pct = 0;
	int stall_pct  = 0;
	int quiet      = 0;
	int n_loads    = 0;
	int n_queries  = 0;
	int n_words    = 0;

	stim_row_t boot_rows [22];
	phase_t    phases [8];

	// Walk the query as the block does. Without commit, return the first store entry the
	// query would read before it is written (colors offset by DUR_DEPTH), or -1 if none.
	// With commit, queue the colors the query must emit.
	function automatic int predict_query(logic [TIME_W-1:0] t, logic [COUNT_W-1:0] cnt,
		bit commit);
		int n, steps, pos;
		bit down;
		logic [TIME_W-1:0] d;
		n     = (cnt > MAX_EMIT_DEF) ? MAX_EMIT_DEF : int'(cnt);
		steps = eff_pp ? 2 * eff_len : eff_len;
		pos   = 0;
		down  = 1'b0;
		for (int i = 0; i < steps; i++) begin
			if (!dur_known[i])
				return i;
			d = {{(TIME_W-DUR_W){dur_store[i][DUR_W-1]}}, dur_store[i]};
			t = t - (d << FRAC_BITS);
			if (t[TIME_W-1]) begin
				pos = i;
				break;
			end
		end
		if (eff_pp && pos > eff_len - 1) begin
			pos  = 2 * eff_len - 1 - pos;
			down = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			if (!color_known[pos])
				return DUR_DEPTH + pos;
			if (commit)
				pending_colors.push_back('{color: color_store[pos], last: (k == n - 1)});
			if (!eff_pp) begin
				pos = (pos + 1 >= eff_len) ? 0 : pos + 1;
			end else if (down) begin
				if (pos == 0)
					down = 1'b0;
				else
					pos--;
			end else begin
				if (pos == eff_len - 1)
					down = 1'b1;
				else
					pos++;
			end
		end
		return -1;
	endfunction

	function automatic logic signed [DUR_W-1:0] pick_duration();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return DUR_W'($urandom_range(1, 8));
		else if (sel < 70)
			return '0;
		else if (sel < 80)
			return -DUR_W'($urandom_range(1, 8));
		return DUR_W'($urandom());
	endfunction

	// Offer one word, hold it until taken, then update the shadow state.
	task automatic send_row(stim_row_t r);
		while ($urandom_range(99) < sender_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= r.mode;
		req_ch.entry_index   <= r.idx;
		req_ch.color_value   <= r.color;
		req_ch.step_duration <= r.dur;
		req_ch.query_time    <= r.qtime;
		req_ch.emit_count    <= r.cnt;
		do @(posedge clk); while (!req_ch.ready);
		case (r.mode)
			MODE_LOAD_COLOR: begin
				n_loads++;
				if (r.idx < MAX_COLORS_DEF) begin
					color_store[r.idx] = r.color;
					color_known[r.idx] = 1'b1;
				end
			end
			MODE_LOAD_DUR: begin
				n_loads++;
				dur_store[r.idx] = r.dur;
				dur_known[r.idx] = 1'b1;
			end
			MODE_QUERY: begin
				n_queries++;
				if (r.typed) begin
					for (int k = 0; k < r.exp_n; k++)
						pending_colors.push_back('{color: r.exp_color,
							last: (k == r.exp_n - 1)});
				end else begin
					void'(predict_query(r.qtime, r.cnt, 1'b1));
				end
			end
			default: ;
		endcase
	endtask

	// Drop valid, drain the colors in flight, then give a trailing search time to finish.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(pce_reg_t r, logic [CFG_DAT_W-1:0] v);
		cfg_ch.index <= r;
		cfg_ch.data  <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (r == REG_EFFECT_MODE)
			eff_pp = v[0];
		else
			eff_len = (v == 0) ? 1 : ((v > MAX_COLORS_DEF) ? MAX_COLORS_DEF : int'(v));
		@(posedge clk);
	endtask

	// result side: check each word taken, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_colors.size() == 0) begin
					$error("out_color: expected no word, got %h", rsp_ch.out_color);
					mismatches++;
				end else begin
					head_word = pending_colors.pop_front();
					n_words++;
					if (rsp_ch.out_color !== head_word.color) begin
						$error("out_color: expected %h, got %h", head_word.color,
							rsp_ch.out_color);
						mismatches++;
					end
					if (rsp_ch.last_of_run !== head_word.last) begin
						$error("last_of_run: expected %0b, got %0b", head_word.last,
							rsp_ch.last_of_run);
						mismatches++;
					end
				end
			end
		end
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$error("no handshake for %0d cycles", quiet);
				$display("palette_cycle_engine_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		stim_row_t fill;
		int miss, steps, sel, done;

		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.mode          <= '0;
		req_ch.entry_index   <= '0;
		req_ch.color_value   <= '0;
		req_ch.step_duration <= '0;
		req_ch.query_time    <= '0;
		req_ch.emit_count    <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= '0;
		cfg_ch.data          <= '0;

		// reset leaves rotate mode with a one-color run, so every query repeats color 0
		boot_rows = '{
			'{MODE_LOAD_COLOR, 9'd0,   16'hFFFF, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_LOAD_DUR,   9'd0,   16'h0,    16'sd1,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd3,   1, 16'hFFFF, 3},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'h7FFFFFFF, 7'd1,   1, 16'hFFFF, 1},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'h80000000, 7'd2,   1, 16'hFFFF, 2},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd0,   1, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd127, 1, 16'hFFFF, 64},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd64,  1, 16'hFFFF, 64},
			'{MODE_UNUSED,     9'd511, 16'hFFFF, -16'sd1,    -32'sd1,      7'd127, 1, 16'h0, 0},
			'{MODE_LOAD_COLOR, 9'd511, 16'h0000, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_LOAD_COLOR, 9'd256, 16'h1234, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd1,   1, 16'hFFFF, 1},
			'{MODE_LOAD_COLOR, 9'd255, 16'hA5A5, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_LOAD_COLOR, 9'd0,   16'h0000, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     -32'sd1,      7'd2,   1, 16'h0000, 2},
			'{MODE_LOAD_DUR,   9'd511, 16'h0,    -16'sd32768, 32'sd0,      7'd0,   0, 16'h0, 0},
			'{MODE_LOAD_DUR,   9'd0,   16'h0,    16'sd32767, 32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'h7FFFFFFF, 7'd5,   0, 16'h0, 0},
			'{MODE_LOAD_DUR,   9'd0,   16'h0,    -16'sd32768, 32'sd0,      7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'h80000000, 7'd1,   0, 16'h0, 0},
			'{MODE_LOAD_COLOR, 9'd1,   16'h5A5A, 16'sd0,     32'sd0,       7'd0,   0, 16'h0, 0},
			'{MODE_QUERY,      9'd0,   16'h0,    16'sd0,     32'sd0,       7'd65,  1, 16'h0000, 64}
		};

		// run lengths of zero and above the store saturate inside the block
		phases = '{
			'{1'b0, 9'd4,   30, 0,  0},
			'{1'b1, 9'd5,   30, 53, 0},
			'{1'b0, 9'd0,   20, 0,  53},
			'{1'b1, 9'd1,   20, 16, 16},
			'{1'b0, 9'd300, 30, 0,  0},
			'{1'b1, 9'd511, 25, 53, 0},
			'{1'b1, 9'd2,   25, 0,  53},
			'{1'b0, 9'd256, 20, 16, 16}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (boot_rows[i])
			send_row(boot_rows[i]);
		settle();

		foreach (phases[p]) begin
			write_reg(REG_EFFECT_MODE, CFG_DAT_W'(phases[p].pingpong));
			write_reg(REG_RUN_LEN, phases[p].count_reg);
			sender_pct = phases[p].sender_pct;
			stall_pct  = phases[p].stall_pct;
			steps = eff_pp ? 2 * eff_len : eff_len;
			done  = 0;
			while (done < phases[p].items) begin
				row = '{default: 0};
				sel = $urandom_range(99);
				if (sel < 50) begin
					row.mode = MODE_QUERY;
					sel = $urandom_range(99);
					if (sel < 60)
						row.qtime = TIME_W'($urandom_range(0, steps * 6 * 256));
					else if (sel < 75)
						row.qtime = TIME_W'($urandom());
					else if (sel < 85)
						row.qtime = 32'sd0 - TIME_W'($urandom_range(0, 4096));
					else
						row.qtime = (TIME_W'($urandom_range(0, steps * 6)) << FRAC_BITS)
							- TIME_W'($urandom_range(0, 1));
					sel = $urandom_range(99);
					if (sel < 70)
						row.cnt = COUNT_W'($urandom_range(1, 12));
					else if (sel < 80)
						row.cnt = '0;
					else if (sel < 90)
						row.cnt = COUNT_W'($urandom_range(13, 64));
					else
						row.cnt = COUNT_W'($urandom_range(65, 127));
					// write whatever the query would read before it is ever loaded
					miss = predict_query(row.qtime, row.cnt, 1'b0);
					while (miss >= 0) begin
						fill = '{default: 0};
						if (miss < DUR_DEPTH) begin
							fill.mode = MODE_LOAD_DUR;
							fill.idx  = INDEX_W'(miss);
							fill.dur  = pick_duration();
						end else begin
							fill.mode  = MODE_LOAD_COLOR;
							fill.idx   = INDEX_W'(miss - DUR_DEPTH);
							fill.color = COLOR_W'($urandom());
						end
						send_row(fill);
						miss = predict_query(row.qtime, row.cnt, 1'b0);
					end
				end else if (sel < 75) begin
					row.mode = MODE_LOAD_DUR;
					row.idx  = INDEX_W'($urandom_range(0, steps - 1));
					row.dur  = pick_duration();
				end else if (sel < 92) begin
					row.mode  = MODE_LOAD_COLOR;
					row.idx   = INDEX_W'($urandom_range(0, eff_len - 1));
					row.color = COLOR_W'($urandom());
				end else if (sel < 97) begin
					row.mode  = $urandom_range(0, 1) ? MODE_LOAD_DUR : MODE_LOAD_COLOR;
					row.idx   = INDEX_W'($urandom_range(0, 511));
					row.color = COLOR_W'($urandom());
					row.dur   = pick_duration();
				end else begin
					row.mode  = MODE_UNUSED;
					row.idx   = INDEX_W'($urandom());
					row.color = COLOR_W'($urandom());
					row.dur   = DUR_W'($urandom());
					row.qtime = TIME_W'($urandom());
					row.cnt   = COUNT_W'($urandom());
				end
				send_row(row);
				if (row.mode != MODE_UNUSED)
					done++;
			end
			settle();
		end

		$display("covered %0d loads and %0d queries over %0d register settings,",
			n_loads, n_queries, $size(phases));
		$display("rotate and ping-pong runs of 1 to 256 colors; %0d colors compared", n_words);
		if (mismatches == 0)
			$display("palette_cycle_engine_tb OK");
		else
			$display("palette_cycle_engine_tb NOT OK");
		$finish;
	end

endmodule
